### sv/indexed_deque_list_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// indexed deque list engine assertion macros
// concurrent assertion helpers on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef INDEXED_DEQUE_LIST_ENGINE_UNIT_MACROS_SVH
`define INDEXED_DEQUE_LIST_ENGINE_UNIT_MACROS_SVH

// assertion clocked on a named clock, disabled by a named active-low reset
`define IDEQ_ASSERT_CLK_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the house clock and reset
`define IDEQ_ASSERT(name, prop, msg) \
  `IDEQ_ASSERT_CLK_RST(name, clk_i, rst_ni, prop, msg)

`endif

### sv/ideq_pkg.sv
// ----------------------------------------------------------------------------
// ideq_pkg
// shared constants and opcode codes of the indexed deque list engine
// ----------------------------------------------------------------------------
package ideq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned OPCODE_W       = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK    = 4'd0,
    OP_PUSH_FRONT   = 4'd1,
    OP_POP_FRONT    = 4'd2,
    OP_READ_AT      = 4'd3,
    OP_UPDATE_AT    = 4'd4,
    OP_INSERT_AFTER = 4'd5,
    OP_REVERSE      = 4'd6,
    OP_CLEAR        = 4'd7,
    OP_READ_FRONT   = 4'd8,
    OP_READ_BACK    = 4'd9
  } op_e;

endpackage

### sv/ideq_req_if.sv
// ----------------------------------------------------------------------------
// ideq_req_if
// request channel: opcode, position and data word with valid/ready
// ----------------------------------------------------------------------------
interface ideq_req_if #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
);
  import ideq_pkg::*;

  localparam int unsigned PosW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                         valid;
  logic                         ready;
  logic [OPCODE_W-1:0]          opcode;
  logic [PosW-1:0]              position;
  logic signed [DATA_WIDTH-1:0] data_in;

  modport source (output valid, opcode, position, data_in, input ready);
  modport sink   (input valid, opcode, position, data_in, output ready);
endinterface

### sv/ideq_rsp_if.sv
// ----------------------------------------------------------------------------
// ideq_rsp_if
// result channel: data word, ok flag, count and empty flag with valid/ready
// ----------------------------------------------------------------------------
interface ideq_rsp_if #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] data_out;
  logic                         ok;
  logic [CntW-1:0]              count_now;
  logic                         is_empty;

  modport source (output valid, data_out, ok, count_now, is_empty, input ready);
  modport sink   (input valid, data_out, ok, count_now, is_empty, output ready);
endinterface

### sv/indexed_deque_list_engine_unit.sv
// ----------------------------------------------------------------------------
// indexed_deque_list_engine_unit
// throughput: one request per cycle, set by the single update of the cell row;
// a stalled result channel (rsp_o.ready low) holds requests in the input stage
// reset: entry count and direction cleared, handshake stages emptied;
// entry cells are not cleared and hold their contents until written
// ----------------------------------------------------------------------------
`include "indexed_deque_list_engine_unit_macros.svh"

module indexed_deque_list_engine_unit #(
  parameter int unsigned DEPTH      = ideq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = ideq_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ideq_req_if.sink   req_i,
  ideq_rsp_if.source rsp_o
);
  import ideq_pkg::*;

  localparam int unsigned PosW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  // input stage
  logic                in_valid_q;
  logic [OPCODE_W-1:0] op_q;
  logic [PosW-1:0]     pos_q;
  word_t               din_q;

  // state
  word_t           store_q [DEPTH];
  word_t           store_d [DEPTH];
  word_t           below   [DEPTH];
  word_t           above   [DEPTH];
  logic [CntW-1:0] count_q, count_d;
  logic            rev_q, rev_d;

  // result stage
  logic            out_valid_q;
  word_t           dout_q, dout_d;
  logic            ok_q, ok_d;

  logic            proc;
  logic            full, empty, pos_ok;
  logic [CntW-1:0] last, pos_ext, lpos;
  logic            ins_en, rem_en, wr_en, rd_en;
  logic [CntW-1:0] ins_at, rem_at, rd_at;
  word_t           rd_data;

  assign proc        = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q  <= req_i.opcode;
      pos_q <= req_i.position;
      din_q <= req_i.data_in;
    end
  end

  // neighbour taps of the cell row
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_tap
    if (gi == 0) begin : g_first
      assign below[gi] = '0;
    end else begin : g_below
      assign below[gi] = store_q[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_last
      assign above[gi] = '0;
    end else begin : g_above
      assign above[gi] = store_q[gi+1];
    end
  end

  assign full    = (count_q == CntW'(DEPTH));
  assign empty   = (count_q == '0);
  assign last    = count_q - CntW'(1);
  assign pos_ext = CntW'(pos_q);
  assign pos_ok  = (pos_ext < count_q);
  assign lpos    = rev_q ? (last - pos_ext) : pos_ext;

  always_comb begin
    ins_en  = 1'b0;
    rem_en  = 1'b0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    ins_at  = '0;
    rem_at  = '0;
    rd_at   = '0;
    ok_d    = 1'b0;
    rev_d   = rev_q;
    count_d = count_q;
    unique case (op_e'(op_q))
      OP_PUSH_BACK: begin
        if (!full) begin
          ins_en = 1'b1;
          ins_at = rev_q ? '0 : count_q;
          ok_d   = 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (!full) begin
          ins_en = 1'b1;
          ins_at = rev_q ? count_q : '0;
          ok_d   = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (!empty) begin
          rem_en = 1'b1;
          rem_at = rev_q ? last : '0;
          rd_en  = 1'b1;
          rd_at  = rem_at;
          ok_d   = 1'b1;
        end
      end
      OP_READ_AT: begin
        if (pos_ok) begin
          rd_en = 1'b1;
          rd_at = lpos;
          ok_d  = 1'b1;
        end
      end
      OP_UPDATE_AT: begin
        if (pos_ok) begin
          wr_en = 1'b1;
          ok_d  = 1'b1;
        end
      end
      OP_INSERT_AFTER: begin
        if (pos_ok && !full) begin
          ins_en = 1'b1;
          ins_at = rev_q ? (last - pos_ext) : (pos_ext + CntW'(1));
          ok_d   = 1'b1;
        end
      end
      OP_REVERSE: begin
        rev_d = !rev_q;
        ok_d  = 1'b1;
      end
      OP_CLEAR: begin
        rev_d   = 1'b0;
        count_d = '0;
        ok_d    = 1'b1;
      end
      OP_READ_FRONT: begin
        if (!empty) begin
          rd_en = 1'b1;
          rd_at = rev_q ? last : '0;
          ok_d  = 1'b1;
        end
      end
      OP_READ_BACK: begin
        if (!empty) begin
          rd_en = 1'b1;
          rd_at = rev_q ? '0 : last;
          ok_d  = 1'b1;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (ins_en) begin
      count_d = count_q + CntW'(1);
    end else if (rem_en) begin
      count_d = last;
    end
  end

  assign rd_data = store_q[rd_at[PosW-1:0]];
  assign dout_d  = rd_en ? rd_data : '0;

  // every cell picks its own next value: hold, shift in a neighbour or load
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      store_d[i] = store_q[i];
      if (ins_en) begin
        if (CntW'(i) == ins_at) begin
          store_d[i] = din_q;
        end else if (CntW'(i) > ins_at && CntW'(i) <= count_q) begin
          store_d[i] = below[i];
        end
      end else if (rem_en) begin
        if (CntW'(i) >= rem_at && CntW'(i) < last) begin
          store_d[i] = above[i];
        end
      end else if (wr_en) begin
        if (CntW'(i) == lpos) begin
          store_d[i] = din_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      store_q <= store_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (proc) begin
      count_q     <= count_d;
      rev_q       <= rev_d;
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      dout_q <= dout_d;
      ok_q   <= ok_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.data_out  = dout_q;
  assign rsp_o.ok        = ok_q;
  assign rsp_o.count_now = count_q;
  assign rsp_o.is_empty  = (count_q == '0);

  `IDEQ_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "entry count beyond depth")
  `IDEQ_ASSERT(a_clear_state, proc && (op_q == OP_CLEAR) |=> (count_q == '0) && !rev_q,
               "clear left entries or reversed order")
  `IDEQ_ASSERT(a_fail_holds, proc && !ok_d |=> count_q == $past(count_q),
               "failed request changed the count")
  `IDEQ_ASSERT(a_result_hold, out_valid_q && !rsp_o.ready |=> out_valid_q && $stable(count_q),
               "stalled result lost or count moved")

endmodule

### sim/indexed_deque_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_deque_list_engine_unit_tb
// self-checking bench for the bounded deque: directed corner requests, then
// random request streams under four handshake idling patterns, every result
// checked against an in-bench model of the list
// ----------------------------------------------------------------------------
module indexed_deque_list_engine_unit_tb;
  import ideq_pkg::*;

  localparam int unsigned DEPTH          = DEPTH_DEF;
  localparam int unsigned DATA_W         = DATA_WIDTH_DEF;
  localparam int unsigned POS_W          = $clog2(DEPTH);
  localparam int unsigned CNT_W          = $clog2(DEPTH + 1);
  localparam int unsigned PHASE_REQUESTS = 150;
  localparam int unsigned IDLE_PCT       = 59;
  localparam int unsigned BOTH_IDLE_PCT  = 33;
  localparam int unsigned DRAIN_CYCLES   = 10;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [DEPTH-1:0][DATA_W-1:0] cells;
    logic [CNT_W-1:0]             count;
    logic                         reversed;
  } deque_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   data;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              ok;
    logic [CNT_W-1:0]  count;
    logic              empty;
  } result_t;

  logic clk_i;
  logic rst_ni;

  ideq_req_if #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_W)) req_if ();
  ideq_rsp_if #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_W)) rsp_if ();

  indexed_deque_list_engine_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_W)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned idle_pct  = IDLE_PCT;
  request_t    pending_requests[$];
  result_t     expected_results[$];
  deque_t      list_state;
  deque_t      stim_state;
  request_t    offered;
  result_t     predicted;
  result_t     observed;
  result_t     wanted;
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned refusals        = 0;
  int unsigned mismatches      = 0;

  function automatic logic [CNT_W-1:0] cell_index(input deque_t s, input logic [CNT_W-1:0] l);
    return s.reversed ? CNT_W'(s.count - 1'b1 - l) : l;
  endfunction

  function automatic deque_t deque_insert(input deque_t s, input logic [CNT_W-1:0] lp,
                                          input logic [DATA_W-1:0] v);
    logic [CNT_W-1:0] q;
    q = s.reversed ? CNT_W'(s.count - lp) : lp;
    for (int i = DEPTH - 1; i > 0; i--)
      if (i > q && i <= s.count) s.cells[i] = s.cells[i - 1];
    s.cells[q[POS_W-1:0]] = v;
    s.count = s.count + 1'b1;
    return s;
  endfunction

  function automatic void deque_apply(input deque_t s_in, input request_t r,
                                      output deque_t s_out, output result_t res);
    deque_t           s;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] q;
    logic             full;
    s    = s_in;
    res  = '0;
    pos  = CNT_W'(r.position);
    full = (s.count >= DEPTH);
    case (r.opcode)
      OP_PUSH_BACK: begin
        if (!full) begin
          s = deque_insert(s, s.count, r.data);
          res.ok = 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (!full) begin
          s = deque_insert(s, '0, r.data);
          res.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (s.count != 0) begin
          q = cell_index(s, '0);
          res.data = s.cells[q[POS_W-1:0]];
          for (int i = 0; i < DEPTH - 1; i++)
            if (i >= q && i + 1 < s.count) s.cells[i] = s.cells[i + 1];
          s.count = s.count - 1'b1;
          res.ok = 1'b1;
        end
      end
      OP_READ_AT: begin
        if (pos < s.count) begin
          q = cell_index(s, pos);
          res.data = s.cells[q[POS_W-1:0]];
          res.ok = 1'b1;
        end
      end
      OP_UPDATE_AT: begin
        if (pos < s.count) begin
          q = cell_index(s, pos);
          s.cells[q[POS_W-1:0]] = r.data;
          res.ok = 1'b1;
        end
      end
      OP_INSERT_AFTER: begin
        if (pos < s.count && !full) begin
          s = deque_insert(s, pos + 1'b1, r.data);
          res.ok = 1'b1;
        end
      end
      OP_REVERSE: begin
        s.reversed = !s.reversed;
        res.ok = 1'b1;
      end
      OP_CLEAR: begin
        s.count = '0;
        s.reversed = 1'b0;
        res.ok = 1'b1;
      end
      OP_READ_FRONT: begin
        if (s.count != 0) begin
          q = cell_index(s, '0);
          res.data = s.cells[q[POS_W-1:0]];
          res.ok = 1'b1;
        end
      end
      OP_READ_BACK: begin
        if (s.count != 0) begin
          q = cell_index(s, s.count - 1'b1);
          res.data = s.cells[q[POS_W-1:0]];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = s.count;
    res.empty = (s.count == 0);
    s_out = s;
  endfunction

  task automatic add_request(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] word);
    request_t r;
    result_t  discard;
    r = '{opcode: op, position: pos, data: word};
    deque_apply(stim_state, r, stim_state, discard);
    pending_requests.push_back(r);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_400_000;
    $display("simulation failed");
    $finish;
  end

  // request driver, prediction taken at each accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.opcode   <= '0;
      req_if.position <= '0;
      req_if.data_in  <= '0;
      list_state = '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        deque_apply(list_state, {req_if.opcode, req_if.position, req_if.data_in},
                    list_state, predicted);
        expected_results.push_back(predicted);
        requests_sent++;
        if (!predicted.ok) refusals++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_requests.size() != 0 &&
            !((idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) &&
              $urandom_range(99) < idle_pct)) begin
          offered = pending_requests.pop_front();
          req_if.valid    <= 1'b1;
          req_if.opcode   <= offered.opcode;
          req_if.position <= offered.position;
          req_if.data_in  <= offered.data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        observed = {rsp_if.data_out, rsp_if.ok, rsp_if.count_now, rsp_if.is_empty};
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: got data %0d ok %0b count %0d empty %0b",
                   $time, $signed(observed.data), observed.ok, observed.count,
                   observed.empty);
        end else begin
          wanted = expected_results.pop_front();
          results_checked++;
          if (observed !== wanted) begin
            mismatches++;
            $display("%0t: mismatch: expected data %0d ok %0b count %0d empty %0b",
                     $time, $signed(wanted.data), wanted.ok, wanted.count, wanted.empty);
            $display("%0t:           actual data %0d ok %0b count %0d empty %0b",
                     $time, $signed(observed.data), observed.ok, observed.count,
                     observed.empty);
          end
        end
      end
      rsp_if.ready <= !((idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH) &&
                        $urandom_range(99) < idle_pct);
    end
  end

  initial begin
    int unsigned         taken;
    int unsigned         pick;
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0]    pos;
    logic [DATA_W-1:0]   word;
    logic                filling;

    rst_ni          = 1'b0;
    stim_state      = '0;
    filling         = 1'b1;

    // empty store refusals and an unused code
    add_request(OP_POP_FRONT, '0, '0);
    add_request(OP_READ_FRONT, '0, '0);
    add_request(OP_READ_BACK, '0, '0);
    add_request(OP_READ_AT, '0, '0);
    add_request(OP_UPDATE_AT, '0, 32'h1234_5678);
    add_request(OP_INSERT_AFTER, '0, 32'h1234_5678);
    add_request(4'(2 ** OPCODE_W - 1), '1, '1);
    // extremes, positions, reversed order
    add_request(OP_PUSH_BACK, '0, 32'h7fff_ffff);
    add_request(OP_PUSH_FRONT, '1, 32'h8000_0000);
    add_request(OP_PUSH_BACK, '0, '0);
    add_request(OP_READ_AT, '0, '0);
    add_request(OP_READ_AT, 4'd3, '0);
    add_request(OP_READ_BACK, '0, '0);
    add_request(OP_REVERSE, '0, '0);
    add_request(OP_READ_AT, '0, '0);
    add_request(OP_INSERT_AFTER, 4'd1, 32'h0bad_cafe);
    add_request(OP_UPDATE_AT, 4'd2, '1);
    add_request(OP_POP_FRONT, '0, '0);
    // fill to the top, then full store refusals and clear
    while (stim_state.count < DEPTH)
      add_request(stim_state.count[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, '0, $urandom);
    add_request(OP_PUSH_BACK, '0, '1);
    add_request(OP_PUSH_FRONT, '0, '1);
    add_request(OP_INSERT_AFTER, '0, '1);
    add_request(OP_CLEAR, '0, '0);
    add_request(OP_READ_FRONT, '0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      while (pending_requests.size() != 0 || req_if.valid) @(negedge clk_i);
      idle_mode = idle_mode_e'(phase);
      idle_pct  = (idle_mode == IDLE_BOTH) ? BOTH_IDLE_PCT : IDLE_PCT;
      taken = 0;
      while (taken < PHASE_REQUESTS) begin
        if (stim_state.count == DEPTH) filling = 1'b0;
        else if (stim_state.count == 0) filling = 1'b1;
        else if ($urandom_range(99) < 3) filling = !filling;
        pick = $urandom_range(99);
        if (pick < (filling ? 42 : 12)) begin
          case ($urandom_range(2))
            0:       op = OP_PUSH_BACK;
            1:       op = OP_PUSH_FRONT;
            default: op = OP_INSERT_AFTER;
          endcase
        end else if (pick < 52) op = OP_POP_FRONT;
        else if (pick < 64) op = OP_READ_AT;
        else if (pick < 77) op = OP_UPDATE_AT;
        else if (pick < 83) op = OP_READ_FRONT;
        else if (pick < 89) op = OP_READ_BACK;
        else if (pick < 95) op = OP_REVERSE;
        else if (pick < 97) op = OP_CLEAR;
        else op = OPCODE_W'($urandom_range(int'(OP_READ_BACK) + 1, 2 ** OPCODE_W - 1));
        if (stim_state.count != 0 && $urandom_range(99) < 85)
          pos = POS_W'($urandom_range(stim_state.count - 1));
        else
          pos = POS_W'($urandom_range(2 ** POS_W - 1));
        case ($urandom_range(9))
          0:       word = 32'h8000_0000;
          1:       word = 32'h7fff_ffff;
          2:       word = '0;
          3:       word = '1;
          default: word = $urandom;
        endcase
        add_request(op, pos, word);
        if (op <= OP_READ_BACK) taken++;
      end
    end

    while (pending_requests.size() != 0 || req_if.valid) @(negedge clk_i);
    idle_mode = IDLE_NONE;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("%0d requests sent over four idling patterns, %0d results checked",
             requests_sent, results_checked);
    $display("%0d requests refused (full, empty, out of range or unused code)", refusals);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
